// File: hw/rtl/ltl_tok_pkg.sv
package ltl_tok_pkg;

    // Token codes
    localparam logic [3:0] T_NEG   = 4'd0;
    localparam logic [3:0] T_IMPL  = 4'd1;
    localparam logic [3:0] T_EQU   = 4'd2;
    localparam logic [3:0] T_EVE   = 4'd3;
    localparam logic [3:0] T_AND   = 4'd4;
    localparam logic [3:0] T_OR    = 4'd5;
    localparam logic [3:0] T_ALW   = 4'd6;
    localparam logic [3:0] T_UNTIL = 4'd7;
    localparam logic [3:0] T_REL   = 4'd8;
    localparam logic [3:0] T_NEXT  = 4'd9;
    localparam logic [3:0] T_LPAR  = 4'd10;
    localparam logic [3:0] T_RPAR  = 4'd11;
    localparam logic [3:0] T_IDCH  = 4'd12;
    localparam logic [3:0] T_ERR   = 4'd13;
    localparam logic [3:0] T_END   = 4'd14;

    // Prefix state codes
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DASH   = 3'd1;
    localparam logic [2:0] S_LT     = 3'd2;
    localparam logic [2:0] S_LTDASH = 3'd3;
    localparam logic [2:0] S_AMP    = 3'd4;
    localparam logic [2:0] S_BAR    = 3'd5;
    localparam logic [2:0] S_LBR    = 3'd6;
    localparam logic [2:0] S_ID     = 3'd7;

    // Character codes
    localparam logic [7:0] C_NUL    = 8'h00;
    localparam logic [7:0] C_BANG   = 8'h21;
    localparam logic [7:0] C_HASH   = 8'h23;
    localparam logic [7:0] C_AMP    = 8'h26;
    localparam logic [7:0] C_LPAR   = 8'h28;
    localparam logic [7:0] C_RPAR   = 8'h29;
    localparam logic [7:0] C_DASH   = 8'h2D;
    localparam logic [7:0] C_LT     = 8'h3C;
    localparam logic [7:0] C_GT     = 8'h3E;
    localparam logic [7:0] C_U      = 8'h55;
    localparam logic [7:0] C_V      = 8'h56;
    localparam logic [7:0] C_X      = 8'h58;
    localparam logic [7:0] C_LBR    = 8'h5B;
    localparam logic [7:0] C_RBR    = 8'h5D;
    localparam logic [7:0] C_LBRACE = 8'h7B;
    localparam logic [7:0] C_BAR    = 8'h7C;
    localparam logic [7:0] C_RBRACE = 8'h7D;

    // Queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    // One classified input character: up to three tokens in order
    typedef struct packed {
        logic [1:0]      cnt;
        logic [2:0][3:0] tok;
        logic [7:0]      idc;
    } job_t;

endpackage

// File: hw/rtl/ltl_operator_tokenizer_unit.sv
// An accepted character is queued; its first token word then enters the output register.
// One character per cycle while each gives at most one token and the output is not stalled;
// a multi-token character holds the output stage, and the four-entry queue absorbs it.
// Reset: rst_n is asynchronous, active low; it returns the prefix state to idle, empties
// the queue and drops any pending output word.
module ltl_operator_tokenizer_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] ch
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] id_char
    output logic [3:0] m_axis_tuser,   // [3:0] token_code
    output logic       m_axis_tlast    // last token word of this character
);

    ltl_tok_pkg::job_t job;
    ltl_tok_pkg::job_t head;
    logic              job_valid;
    logic              accept;
    logic              pop;
    logic              q_empty;
    logic              q_full;

    // Accept a character whenever the queue has room; the front never stalls otherwise.
    assign s_axis_tready = !q_full;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Front: track the pending prefix and turn each character into up to three tokens.
    ltl_tok_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .ch        (s_axis_tdata),
        .accept    (accept),
        .job       (job),
        .job_valid (job_valid)
    );

    // Queue: hold classified characters so front and back stall independently.
    ltl_tok_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (job_valid),
        .push_data (job),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    // Back: emit head tokens one word per cycle unless stalled; advance on the last one.
    ltl_tok_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .empty   (q_empty),
        .pop     (pop),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_code  (m_axis_tuser),
        .m_idc   (m_axis_tdata),
        .m_last  (m_axis_tlast)
    );

endmodule

// File: hw/rtl/ltl_tok_front.sv
module ltl_tok_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          ch,
    input  logic                accept,
    output ltl_tok_pkg::job_t   job,
    output logic                job_valid
);

    logic [2:0] state_reg;
    logic [2:0] state_next;

    // Classification of ch as seen from idle
    logic       fi_valid;
    logic [3:0] fi_code;
    logic [2:0] fi_state;

    always_comb
    begin
        fi_valid = 1'b1;
        fi_code  = ltl_tok_pkg::T_ERR;
        fi_state = ltl_tok_pkg::S_IDLE;
        case (ch)
            ltl_tok_pkg::C_BANG:   fi_code = ltl_tok_pkg::T_NEG;
            ltl_tok_pkg::C_U:      fi_code = ltl_tok_pkg::T_UNTIL;
            ltl_tok_pkg::C_V:      fi_code = ltl_tok_pkg::T_REL;
            ltl_tok_pkg::C_X:      fi_code = ltl_tok_pkg::T_NEXT;
            ltl_tok_pkg::C_LPAR:   fi_code = ltl_tok_pkg::T_LPAR;
            ltl_tok_pkg::C_RPAR:   fi_code = ltl_tok_pkg::T_RPAR;
            ltl_tok_pkg::C_DASH:
            begin
                fi_valid = 1'b0;
                fi_state = ltl_tok_pkg::S_DASH;
            end
            ltl_tok_pkg::C_LT:
            begin
                fi_valid = 1'b0;
                fi_state = ltl_tok_pkg::S_LT;
            end
            ltl_tok_pkg::C_AMP:
            begin
                fi_valid = 1'b0;
                fi_state = ltl_tok_pkg::S_AMP;
            end
            ltl_tok_pkg::C_BAR:
            begin
                fi_valid = 1'b0;
                fi_state = ltl_tok_pkg::S_BAR;
            end
            ltl_tok_pkg::C_LBR:
            begin
                fi_valid = 1'b0;
                fi_state = ltl_tok_pkg::S_LBR;
            end
            ltl_tok_pkg::C_LBRACE:
            begin
                fi_code  = ltl_tok_pkg::T_IDCH;
                fi_state = ltl_tok_pkg::S_ID;
            end
            ltl_tok_pkg::C_NUL,
            ltl_tok_pkg::C_HASH:   fi_code = ltl_tok_pkg::T_END;
            default:               fi_code = ltl_tok_pkg::T_ERR;
        endcase
    end

    // Second character of a two-character token
    logic [7:0] want;
    logic [3:0] pair_code;

    always_comb
    begin
        case (state_reg)
            ltl_tok_pkg::S_DASH:
            begin
                want      = ltl_tok_pkg::C_GT;
                pair_code = ltl_tok_pkg::T_IMPL;
            end
            ltl_tok_pkg::S_LT:
            begin
                want      = ltl_tok_pkg::C_GT;
                pair_code = ltl_tok_pkg::T_EVE;
            end
            ltl_tok_pkg::S_AMP:
            begin
                want      = ltl_tok_pkg::C_AMP;
                pair_code = ltl_tok_pkg::T_AND;
            end
            ltl_tok_pkg::S_BAR:
            begin
                want      = ltl_tok_pkg::C_BAR;
                pair_code = ltl_tok_pkg::T_OR;
            end
            default:
            begin
                want      = ltl_tok_pkg::C_RBR;
                pair_code = ltl_tok_pkg::T_ALW;
            end
        endcase
    end

    always_comb
    begin
        job.cnt    = 2'd0;
        job.tok    = '0;
        job.idc    = ch;
        state_next = ltl_tok_pkg::S_IDLE;
        case (state_reg)
            ltl_tok_pkg::S_IDLE:
            begin
                job.cnt    = {1'b0, fi_valid};
                job.tok[0] = fi_code;
                state_next = fi_state;
            end
            ltl_tok_pkg::S_LTDASH:
            begin
                if (ch == ltl_tok_pkg::C_GT)
                begin
                    job.cnt    = 2'd1;
                    job.tok[0] = ltl_tok_pkg::T_EQU;
                end
                else
                begin
                    // error for '<', error for '-', then ch from idle
                    job.cnt    = 2'd2 + {1'b0, fi_valid};
                    job.tok[0] = ltl_tok_pkg::T_ERR;
                    job.tok[1] = ltl_tok_pkg::T_ERR;
                    job.tok[2] = fi_code;
                    state_next = fi_state;
                end
            end
            ltl_tok_pkg::S_ID:
            begin
                if (ch == ltl_tok_pkg::C_NUL)
                begin
                    job.cnt    = 2'd2;
                    job.tok[0] = ltl_tok_pkg::T_ERR;
                    job.tok[1] = ltl_tok_pkg::T_END;
                end
                else
                begin
                    job.cnt    = 2'd1;
                    job.tok[0] = ltl_tok_pkg::T_IDCH;
                    state_next = (ch == ltl_tok_pkg::C_RBRACE) ? ltl_tok_pkg::S_IDLE
                                                               : ltl_tok_pkg::S_ID;
                end
            end
            default:
            begin
                if (state_reg == ltl_tok_pkg::S_LT && ch == ltl_tok_pkg::C_DASH)
                begin
                    state_next = ltl_tok_pkg::S_LTDASH;
                end
                else if (ch == want)
                begin
                    job.cnt    = 2'd1;
                    job.tok[0] = pair_code;
                end
                else
                begin
                    // error for the pending character, then ch from idle
                    job.cnt    = 2'd1 + {1'b0, fi_valid};
                    job.tok[0] = ltl_tok_pkg::T_ERR;
                    job.tok[1] = fi_code;
                    state_next = fi_state;
                end
            end
        endcase
    end

    assign job_valid = accept && (job.cnt != 2'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ltl_tok_pkg::S_IDLE;
        end
        else if (accept)
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: hw/rtl/ltl_tok_queue.sv
module ltl_tok_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ltl_tok_pkg::job_t   push_data,
    input  logic                pop,
    output ltl_tok_pkg::job_t   head,
    output logic                empty,
    output logic                full
);

    ltl_tok_pkg::job_t             mem_reg [ltl_tok_pkg::QDEPTH];
    logic [ltl_tok_pkg::QAW-1:0]   wr_ptr_reg;
    logic [ltl_tok_pkg::QAW-1:0]   rd_ptr_reg;
    logic [ltl_tok_pkg::QAW:0]     count_reg;
    logic [ltl_tok_pkg::QAW:0]     count_next;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (ltl_tok_pkg::QAW+1)'(ltl_tok_pkg::QDEPTH));
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// File: hw/rtl/ltl_tok_back.sv
module ltl_tok_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ltl_tok_pkg::job_t   head,
    input  logic                empty,
    output logic                pop,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [3:0]          m_code,
    output logic [7:0]          m_idc,
    output logic                m_last
);

    logic       out_valid_reg;
    logic [3:0] out_code_reg;
    logic [7:0] out_idc_reg;
    logic       out_last_reg;
    logic [1:0] pos_reg;

    logic       load;
    logic       take;
    logic       is_last;
    logic [3:0] sel_code;

    assign load     = !out_valid_reg || m_ready;
    assign take     = load && !empty;
    assign is_last  = (pos_reg == head.cnt - 2'd1);
    assign sel_code = head.tok[pos_reg];
    assign pop      = take && is_last;

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_code_reg <= sel_code;
            out_idc_reg  <= (sel_code == ltl_tok_pkg::T_IDCH) ? head.idc : 8'd0;
            out_last_reg <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= 2'd0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= !empty;
            end
            if (take)
            begin
                pos_reg <= is_last ? 2'd0 : pos_reg + 2'd1;
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_code  = out_code_reg;
    assign m_idc   = out_idc_reg;
    assign m_last  = out_last_reg;

endmodule

// File: hw/rtl/ltl_tok_checker.sv
module ltl_tok_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic [3:0] m_axis_tuser,
    input logic       m_axis_tlast
);

    // Hold a stalled word.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output word changed while stalled");

    // Identifier byte only on identifier-character words.
    a_idc_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ltl_tok_pkg::T_IDCH) |-> m_axis_tdata == 8'd0)
        else $error("nonzero id_char on a non-identifier token");

    // End of formula always closes the character's token run.
    a_end_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == ltl_tok_pkg::T_END) |-> m_axis_tlast)
        else $error("end token not marked last");

endmodule

bind ltl_operator_tokenizer_unit ltl_tok_checker u_ltl_tok_checker (.*);
